>>> rtl/core/ccp_pkg.sv
// Shared types, widths and constants for the Christoffel characteristic-polynomial unit.
// No dependencies; imported by ccp_gamma_pipe, ccp_coef_pipe and the top level.
package ccp_pkg;

    // Port widths
    localparam int DIR_W     = 16;
    localparam int STIFF_W   = 16;
    localparam int GAM_W     = 32;
    localparam int SQ_W      = 32;
    localparam int LIN_W     = 48;
    localparam int CONST_W   = 64;
    localparam int CFG_IDX_W = 3;

    // Pipeline depth
    localparam int GAM_STG  = 5;
    localparam int COEF_STG = 5;
    localparam int PIPE_STG = GAM_STG + COEF_STG;

    // Entry width: |entry| <= 5*2^23 + 1 for any 16-bit operands
    localparam int ENT_W = 27;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFF_11 = 3'd0,
        CFG_STIFF_12 = 3'd1,
        CFG_STIFF_13 = 3'd2,
        CFG_STIFF_33 = 3'd3,
        CFG_STIFF_44 = 3'd4,
        CFG_STIFF_66 = 3'd5,
        CFG_STIFF_16 = 3'd6
    } t_cfg_idx;

    localparam logic signed [STIFF_W-1:0] STIFF_11_RST = 16'sd1434;
    localparam logic signed [STIFF_W-1:0] STIFF_12_RST = 16'sd1306;
    localparam logic signed [STIFF_W-1:0] STIFF_13_RST = 16'sd563;
    localparam logic signed [STIFF_W-1:0] STIFF_33_RST = 16'sd2714;
    localparam logic signed [STIFF_W-1:0] STIFF_44_RST = 16'sd678;
    localparam logic signed [STIFF_W-1:0] STIFF_66_RST = 16'sd1690;
    localparam logic signed [STIFF_W-1:0] STIFF_16_RST = 16'sd0;

    typedef struct packed {
        logic signed [STIFF_W-1:0] c11;
        logic signed [STIFF_W-1:0] c12;
        logic signed [STIFF_W-1:0] c13;
        logic signed [STIFF_W-1:0] c33;
        logic signed [STIFF_W-1:0] c44;
        logic signed [STIFF_W-1:0] c66;
        logic signed [STIFF_W-1:0] c16;
    } t_stiff;

    // Six distinct matrix entries, Q.16
    typedef struct packed {
        logic signed [ENT_W-1:0] g11;
        logic signed [ENT_W-1:0] g12;
        logic signed [ENT_W-1:0] g13;
        logic signed [ENT_W-1:0] g22;
        logic signed [ENT_W-1:0] g23;
        logic signed [ENT_W-1:0] g33;
    } t_gam;

    // Per-stage advance enables, one bit per stage
    typedef struct packed {
        logic [GAM_STG-1:0]  gam;
        logic [COEF_STG-1:0] coef;
    } t_stage_en;

endpackage

>>> rtl/core/ccp_gamma_pipe.sv
// Stages 0..4: direction products, stiffness products, sums, rounding to matrix entries.
// Depends on ccp_pkg.
module ccp_gamma_pipe (
    input  logic                                i_clk,
    input  logic [ccp_pkg::GAM_STG-1:0]         i_en,
    input  ccp_pkg::t_stiff                     i_stiff,
    input  logic signed [ccp_pkg::DIR_W-1:0]    i_dir_x,
    input  logic signed [ccp_pkg::DIR_W-1:0]    i_dir_y,
    input  logic signed [ccp_pkg::DIR_W-1:0]    i_dir_z,
    output ccp_pkg::t_gam                       o_gam
);
    import ccp_pkg::*;

    localparam int SQ2_W    = 2 * DIR_W;      // n_i * n_j
    localparam int SQX_W    = SQ2_W + 1;      // s11 +/- s22
    localparam int CS_W     = STIFF_W + 1;    // stiffness sums
    localparam int PROD_W   = 50;
    localparam int EXACT_W  = 51;             // |exact| <= 5*2^45
    localparam int ENT_DROP = 22;
    localparam logic signed [EXACT_W-1:0] ENT_HALF = EXACT_W'(1) <<< (ENT_DROP - 1);

    // stage 0: direction
    logic signed [DIR_W-1:0] r_n1, r_n2, r_n3;
    // stage 1: second-order products
    logic signed [SQ2_W-1:0] r_s11, r_s22, r_s33, r_s12, r_s13, r_s23;
    // stage 2: stiffness products
    logic signed [PROD_W-1:0] r_ta, r_tb, r_tc, r_td, r_te, r_tf;
    logic signed [PROD_W-1:0] r_tg, r_th, r_ti, r_tj, r_tk, r_tl;
    // stage 3: exact entries, 38 fraction bits
    logic signed [EXACT_W-1:0] r_e11, r_e12, r_e13, r_e22, r_e23, r_e33;
    // stage 4: rounded entries
    t_gam r_gam;

    logic signed [STIFF_W-1:0] c11, c33, c44, c66, c16;
    logic signed [CS_W-1:0]    w_c1266, w_c1344, w_c16x2;
    logic signed [SQX_W-1:0]   w_sdif, w_ssum;

    assign c11 = $signed(i_stiff.c11);
    assign c33 = $signed(i_stiff.c33);
    assign c44 = $signed(i_stiff.c44);
    assign c66 = $signed(i_stiff.c66);
    assign c16 = $signed(i_stiff.c16);

    assign w_c1266 = CS_W'($signed(i_stiff.c12)) + CS_W'(c66);
    assign w_c1344 = CS_W'($signed(i_stiff.c13)) + CS_W'(c44);
    assign w_c16x2 = CS_W'(c16) <<< 1;
    assign w_sdif  = SQX_W'(r_s11) - SQX_W'(r_s22);
    assign w_ssum  = SQX_W'(r_s11) + SQX_W'(r_s22);

    function automatic logic signed [ENT_W-1:0] round_entry(
        input logic signed [EXACT_W-1:0] e
    );
        logic signed [EXACT_W-1:0] t;
        t = e + ENT_HALF;
        return ENT_W'(t >>> ENT_DROP);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_n1 <= i_dir_x;
            r_n2 <= i_dir_y;
            r_n3 <= i_dir_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s11 <= SQ2_W'(r_n1) * SQ2_W'(r_n1);
            r_s22 <= SQ2_W'(r_n2) * SQ2_W'(r_n2);
            r_s33 <= SQ2_W'(r_n3) * SQ2_W'(r_n3);
            r_s12 <= SQ2_W'(r_n1) * SQ2_W'(r_n2);
            r_s13 <= SQ2_W'(r_n1) * SQ2_W'(r_n3);
            r_s23 <= SQ2_W'(r_n2) * SQ2_W'(r_n3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_ta <= PROD_W'(c11)     * PROD_W'(r_s11);
            r_tb <= PROD_W'(c66)     * PROD_W'(r_s22);
            r_tc <= PROD_W'(c44)     * PROD_W'(r_s33);
            r_td <= PROD_W'(w_c16x2) * PROD_W'(r_s12);
            r_te <= PROD_W'(c16)     * PROD_W'(w_sdif);
            r_tf <= PROD_W'(w_c1266) * PROD_W'(r_s12);
            r_tg <= PROD_W'(w_c1344) * PROD_W'(r_s13);
            r_th <= PROD_W'(c66)     * PROD_W'(r_s11);
            r_ti <= PROD_W'(c11)     * PROD_W'(r_s22);
            r_tj <= PROD_W'(w_c1344) * PROD_W'(r_s23);
            r_tk <= PROD_W'(c44)     * PROD_W'(w_ssum);
            r_tl <= PROD_W'(c33)     * PROD_W'(r_s33);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_e11 <= EXACT_W'(r_ta) + EXACT_W'(r_tb) + EXACT_W'(r_tc) + EXACT_W'(r_td);
            r_e12 <= EXACT_W'(r_te) + EXACT_W'(r_tf);
            r_e13 <= EXACT_W'(r_tg);
            r_e22 <= EXACT_W'(r_th) + EXACT_W'(r_ti) + EXACT_W'(r_tc) - EXACT_W'(r_td);
            r_e23 <= EXACT_W'(r_tj);
            r_e33 <= EXACT_W'(r_tk) + EXACT_W'(r_tl);
        end
    end

    // Entries are bounded inside ENT_W bits, so the narrowing in round_entry loses nothing.
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_gam.g11 <= round_entry(r_e11);
            r_gam.g12 <= round_entry(r_e12);
            r_gam.g13 <= round_entry(r_e13);
            r_gam.g22 <= round_entry(r_e22);
            r_gam.g23 <= round_entry(r_e23);
            r_gam.g33 <= round_entry(r_e33);
        end
    end

    assign o_gam = r_gam;

endmodule

>>> rtl/core/ccp_coef_pipe.sv
// Stages 5..9: trace, pairwise products, minors and their sum, cofactor expansion of det.
// Depends on ccp_pkg.
module ccp_coef_pipe (
    input  logic                                i_clk,
    input  logic [ccp_pkg::COEF_STG-1:0]        i_en,
    input  ccp_pkg::t_gam                       i_gam,
    output ccp_pkg::t_gam                       o_gam,
    output logic signed [ccp_pkg::SQ_W-1:0]     o_coef_sq,
    output logic signed [ccp_pkg::LIN_W-1:0]    o_coef_lin,
    output logic signed [ccp_pkg::CONST_W-1:0]  o_coef_const
);
    import ccp_pkg::*;

    localparam int TR_W      = ENT_W + 2;            // trace
    localparam int PP_W      = 2 * ENT_W;            // g*g
    localparam int MIN_W     = PP_W + 1;             // 2x2 minor
    localparam int LSUM_W    = MIN_W + 2;            // sum of three minors
    localparam int LIN_DROP  = 16;
    localparam int LR_W      = LSUM_W - LIN_DROP;
    localparam int ML_W      = 28;                   // low split of a minor
    localparam int MH_W      = MIN_W - ML_W;
    localparam int PH_W      = ENT_W + MH_W;
    localparam int PL_W      = ENT_W + ML_W + 1;
    localparam int TERM_W    = PH_W + ML_W + 2;
    localparam int DET_W     = TERM_W + 2;
    localparam int DET_DROP  = 32;
    localparam logic signed [LSUM_W-1:0] LIN_HALF = LSUM_W'(1) <<< (LIN_DROP - 1);
    localparam logic signed [DET_W-1:0]  DET_HALF = DET_W'(1) <<< (DET_DROP - 1);

    // stage 5
    t_gam                   r5_gam;
    logic signed [TR_W-1:0] r5_sq;
    logic signed [PP_W-1:0] r5_p2233, r5_p2323, r5_p1133, r5_p1313, r5_p1122;
    logic signed [PP_W-1:0] r5_p1212, r5_p1233, r5_p2313, r5_p1223, r5_p2213;
    // stage 6
    t_gam                    r6_gam;
    logic signed [TR_W-1:0]  r6_sq;
    logic signed [MIN_W-1:0] r6_m1, r6_m2, r6_m3, r6_p11, r6_p33;
    // stage 7
    t_gam                    r7_gam;
    logic signed [TR_W-1:0]  r7_sq;
    logic signed [LR_W-1:0]  r7_lin;
    logic signed [PH_W-1:0]  r7_h1, r7_h2, r7_h3;
    logic signed [PL_W-1:0]  r7_l1, r7_l2, r7_l3;
    // stage 8
    t_gam                     r8_gam;
    logic signed [TR_W-1:0]   r8_sq;
    logic signed [LR_W-1:0]   r8_lin;
    logic signed [TERM_W-1:0] r8_t1, r8_t2, r8_t3;
    // stage 9
    t_gam                      r9_gam;
    logic signed [SQ_W-1:0]    r9_sq;
    logic signed [LIN_W-1:0]   r9_lin;
    logic signed [CONST_W-1:0] r9_const;

    logic signed [ENT_W-1:0] g11, g12, g13, g22, g23, g33;
    logic signed [LSUM_W-1:0] n7_lin_sum;
    logic signed [DET_W-1:0]  n9_det;

    assign g11 = $signed(i_gam.g11);
    assign g12 = $signed(i_gam.g12);
    assign g13 = $signed(i_gam.g13);
    assign g22 = $signed(i_gam.g22);
    assign g23 = $signed(i_gam.g23);
    assign g33 = $signed(i_gam.g33);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r5_gam   <= i_gam;
            r5_sq    <= -(TR_W'(g11) + TR_W'(g22) + TR_W'(g33));
            r5_p2233 <= PP_W'(g22) * PP_W'(g33);
            r5_p2323 <= PP_W'(g23) * PP_W'(g23);
            r5_p1133 <= PP_W'(g11) * PP_W'(g33);
            r5_p1313 <= PP_W'(g13) * PP_W'(g13);
            r5_p1122 <= PP_W'(g11) * PP_W'(g22);
            r5_p1212 <= PP_W'(g12) * PP_W'(g12);
            r5_p1233 <= PP_W'(g12) * PP_W'(g33);
            r5_p2313 <= PP_W'(g23) * PP_W'(g13);
            r5_p1223 <= PP_W'(g12) * PP_W'(g23);
            r5_p2213 <= PP_W'(g22) * PP_W'(g13);
        end
    end

    // m1..m3 are the minors along the first row; p11, p33 the other principal minors
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r6_gam <= r5_gam;
            r6_sq  <= r5_sq;
            r6_m1  <= MIN_W'(r5_p2233) - MIN_W'(r5_p2323);
            r6_m2  <= MIN_W'(r5_p1233) - MIN_W'(r5_p2313);
            r6_m3  <= MIN_W'(r5_p1223) - MIN_W'(r5_p2213);
            r6_p11 <= MIN_W'(r5_p1133) - MIN_W'(r5_p1313);
            r6_p33 <= MIN_W'(r5_p1122) - MIN_W'(r5_p1212);
        end
    end

    always_comb begin
        n7_lin_sum = LSUM_W'(r6_m1) + LSUM_W'(r6_p11) + LSUM_W'(r6_p33) + LIN_HALF;
    end

    // Each g * minor is split into a high and a low partial product.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r7_gam <= r6_gam;
            r7_sq  <= r6_sq;
            r7_lin <= LR_W'(n7_lin_sum >>> LIN_DROP);
            r7_h1  <= PH_W'($signed(r6_gam.g11)) * PH_W'($signed(r6_m1[MIN_W-1:ML_W]));
            r7_h2  <= PH_W'($signed(r6_gam.g12)) * PH_W'($signed(r6_m2[MIN_W-1:ML_W]));
            r7_h3  <= PH_W'($signed(r6_gam.g13)) * PH_W'($signed(r6_m3[MIN_W-1:ML_W]));
            r7_l1  <= PL_W'($signed(r6_gam.g11)) * PL_W'($signed({1'b0, r6_m1[ML_W-1:0]}));
            r7_l2  <= PL_W'($signed(r6_gam.g12)) * PL_W'($signed({1'b0, r6_m2[ML_W-1:0]}));
            r7_l3  <= PL_W'($signed(r6_gam.g13)) * PL_W'($signed({1'b0, r6_m3[ML_W-1:0]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r8_gam <= r7_gam;
            r8_sq  <= r7_sq;
            r8_lin <= r7_lin;
            r8_t1  <= (TERM_W'(r7_h1) <<< ML_W) + TERM_W'(r7_l1);
            r8_t2  <= (TERM_W'(r7_h2) <<< ML_W) + TERM_W'(r7_l2);
            r8_t3  <= (TERM_W'(r7_h3) <<< ML_W) + TERM_W'(r7_l3);
        end
    end

    always_comb begin
        n9_det = -(DET_W'(r8_t1) - DET_W'(r8_t2) + DET_W'(r8_t3)) + DET_HALF;
    end

    // Operand bounds keep every coefficient inside its port width, so the casts lose nothing.
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r9_gam   <= r8_gam;
            r9_sq    <= SQ_W'(r8_sq);
            r9_lin   <= LIN_W'(r8_lin);
            r9_const <= CONST_W'(n9_det >>> DET_DROP);
        end
    end

    assign o_gam        = r9_gam;
    assign o_coef_sq    = r9_sq;
    assign o_coef_lin   = r9_lin;
    assign o_coef_const = r9_const;

endmodule

>>> rtl/core/christoffel_char_poly_unit.sv
// Christoffel matrix and monic characteristic cubic of a tetragonal crystal, top level.
// Depends on ccp_pkg, ccp_gamma_pipe and ccp_coef_pipe.
//
//  channel   direction  handshake                     payload
//  --------  ---------  ----------------------------  ----------------------------------
//  request   in         i_in_valid / o_in_stall        i_dir_x, i_dir_y, i_dir_z (Q1.15)
//  result    out        o_out_valid / i_out_stall      o_gam_*, o_coef_sq/lin/const
//  config    in         i_cfg_we (write only)          i_cfg_idx, i_cfg_data (Q8.8)
//
// Flow: one request per clock sustained while i_out_stall is low; a result passes
//   through the ten register stages (two multiplier ranks before the entries, two
//   after, plus sums, rounding and the determinant's split partial products).
// Reset (i_rst_n low, synchronous): clears every stage valid bit and reloads the
//   seven stiffness registers with their default constants.
// Stalls: each stage moves when it is empty or the next stage moves, so bubbles close
//   up and requests are still taken under i_out_stall while any stage is empty.
module christoffel_char_poly_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [ccp_pkg::DIR_W-1:0]      i_dir_x,
    input  logic signed [ccp_pkg::DIR_W-1:0]      i_dir_y,
    input  logic signed [ccp_pkg::DIR_W-1:0]      i_dir_z,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ccp_pkg::GAM_W-1:0]      o_gam_11,
    output logic signed [ccp_pkg::GAM_W-1:0]      o_gam_12,
    output logic signed [ccp_pkg::GAM_W-1:0]      o_gam_13,
    output logic signed [ccp_pkg::GAM_W-1:0]      o_gam_22,
    output logic signed [ccp_pkg::GAM_W-1:0]      o_gam_23,
    output logic signed [ccp_pkg::GAM_W-1:0]      o_gam_33,
    output logic signed [ccp_pkg::SQ_W-1:0]       o_coef_sq,
    output logic signed [ccp_pkg::LIN_W-1:0]      o_coef_lin,
    output logic signed [ccp_pkg::CONST_W-1:0]    o_coef_const,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [ccp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ccp_pkg::STIFF_W-1:0]           i_cfg_data
);
    import ccp_pkg::*;

    t_stiff                r_stiff;
    logic [PIPE_STG-1:0]   r_vld;     // valid bit per stage, index 0 = input stage
    logic [PIPE_STG-1:0]   w_adv;     // stage k loads this cycle
    t_stage_en             w_en;
    t_gam                  w_gam_mid;
    t_gam                  w_gam_out;

    // Stiffness registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff.c11 <= STIFF_11_RST;
            r_stiff.c12 <= STIFF_12_RST;
            r_stiff.c13 <= STIFF_13_RST;
            r_stiff.c33 <= STIFF_33_RST;
            r_stiff.c44 <= STIFF_44_RST;
            r_stiff.c66 <= STIFF_66_RST;
            r_stiff.c16 <= STIFF_16_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STIFF_11: begin
                    r_stiff.c11 <= $signed(i_cfg_data);
                end
                CFG_STIFF_12: begin
                    r_stiff.c12 <= $signed(i_cfg_data);
                end
                CFG_STIFF_13: begin
                    r_stiff.c13 <= $signed(i_cfg_data);
                end
                CFG_STIFF_33: begin
                    r_stiff.c33 <= $signed(i_cfg_data);
                end
                CFG_STIFF_44: begin
                    r_stiff.c44 <= $signed(i_cfg_data);
                end
                CFG_STIFF_66: begin
                    r_stiff.c66 <= $signed(i_cfg_data);
                end
                CFG_STIFF_16: begin
                    r_stiff.c16 <= $signed(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    // Advance chain, from the output back to the input.
    always_comb begin
        w_adv[PIPE_STG-1] = !r_vld[PIPE_STG-1] || !i_out_stall;
        for (int k = PIPE_STG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign w_en.gam  = w_adv[GAM_STG-1:0];
    assign w_en.coef = w_adv[PIPE_STG-1:GAM_STG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_STG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    ccp_gamma_pipe u_gamma (
        .i_clk   (i_clk),
        .i_en    (w_en.gam),
        .i_stiff (r_stiff),
        .i_dir_x (i_dir_x),
        .i_dir_y (i_dir_y),
        .i_dir_z (i_dir_z),
        .o_gam   (w_gam_mid)
    );

    ccp_coef_pipe u_coef (
        .i_clk        (i_clk),
        .i_en         (w_en.coef),
        .i_gam        (w_gam_mid),
        .o_gam        (w_gam_out),
        .o_coef_sq    (o_coef_sq),
        .o_coef_lin   (o_coef_lin),
        .o_coef_const (o_coef_const)
    );

    assign o_in_stall  = !w_adv[0];
    assign o_out_valid = r_vld[PIPE_STG-1];

    // Entries are carried narrow; sign-extend to Q15.16 ports.
    assign o_gam_11 = GAM_W'($signed(w_gam_out.g11));
    assign o_gam_12 = GAM_W'($signed(w_gam_out.g12));
    assign o_gam_13 = GAM_W'($signed(w_gam_out.g13));
    assign o_gam_22 = GAM_W'($signed(w_gam_out.g22));
    assign o_gam_23 = GAM_W'($signed(w_gam_out.g23));
    assign o_gam_33 = GAM_W'($signed(w_gam_out.g33));

endmodule
